// ===== rtl/core/tmsof_pkg.sv =====
// Shared constants and types for the trimmed-mean size outlier filter.
package tmsof_pkg;

    // Set capacity and field widths.
    localparam int MAX_RECTS   = 64;
    localparam int LENGTH_BITS = 12;
    localparam int RATIO_W     = 8;
    localparam int IDX_W       = $clog2(MAX_RECTS);
    localparam int CNT_W       = $clog2(MAX_RECTS + 1);
    localparam int SUM_W       = LENGTH_BITS + IDX_W;
    localparam int N8_W        = CNT_W + 3;
    localparam int RECT_IDX_W  = 6;

    // Stream widths: input tdata carries width and height, output tdata
    // carries index, keep and overflow flag.
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 8;

    // Shared multiplier operand widths.
    localparam int MUL_A_W     = SUM_W;
    localparam int MUL_B_W     = (N8_W > RATIO_W) ? N8_W : RATIO_W;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

    // Configuration register indexes.
    localparam int CFG_IDX_W   = 1;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_CAP  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_RATIO  = 1'd1;
    localparam int CFG_DATA_W  = 12;

    // Reset values of the configuration registers.
    localparam logic [LENGTH_BITS-1:0] LENGTH_CAP_RST = LENGTH_BITS'(450);
    localparam logic [RATIO_W-1:0]     KEEP_RATIO_RST = RATIO_W'(12);

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_TRIM,
        S_RHS,
        S_SCALE,
        S_LMUL,
        S_JUDGE,
        S_EMIT
    } state_t;

    // Operand selection for the shared multiplier.
    typedef enum logic {
        MUL_SEL_RHS,
        MUL_SEL_LEN
    } mul_sel_t;

endpackage

// ===== rtl/core/tmsof_mul.sv =====
// Shared multiplier with a registered product.
module tmsof_mul
    import tmsof_pkg::*;
(
    input  logic               clk,
    input  logic [MUL_A_W-1:0] op_a,
    input  logic [MUL_B_W-1:0] op_b,
    output logic [MUL_P_W-1:0] product
);

    logic [MUL_P_W-1:0] product_reg;
    logic [MUL_P_W-1:0] product_next;

    // Unsigned multiply, registered before use.
    assign product_next = MUL_P_W'(op_a) * MUL_P_W'(op_b);

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
    end

    assign product = product_reg;

endmodule

// ===== rtl/core/trimmed_mean_size_outlier_filter.sv =====
// Top level of the trimmed-mean size outlier filter.
//
// Rectangles load one per cycle on the input stream while the block is idle;
// each stores its larger side in a 64-entry length memory and updates running
// sums, counts, minima and maxima for the capped and the full set. The item
// marked with tlast ends the set: the block drops ready, forms the trimmed
// count and sum and then the product ratio times sum (TRIM, RHS, SCALE), then
// judges the stored lengths in load order (memory read, shared multiplier,
// compare into the output register), one result at a time, each held until
// it is taken. No new rectangle is accepted until the last result of the set
// has been taken. Items beyond 64 are dropped and flagged in every result of
// the set. Configuration writes are always taken and should be issued while idle.
module trimmed_mean_size_outlier_filter
    import tmsof_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // Input stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // [11:0] rect_width, [23:12] rect_height
    input  logic                   s_axis_tlast,   // last_rect
    // Result stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // [5:0] rect_index, [6] keep, [7] overflowed
    output logic                   m_axis_tlast    // last_result
);

    // Sequencer state.
    state_t state_reg, state_next;

    // Configuration registers.
    logic [LENGTH_BITS-1:0] length_cap_reg;
    logic [RATIO_W-1:0]     keep_ratio_reg;

    // Set statistics.
    logic [CNT_W-1:0]       entry_count_reg;
    logic [SUM_W-1:0]       capped_sum_reg;
    logic [CNT_W-1:0]       capped_count_reg;
    logic [LENGTH_BITS-1:0] capped_min_reg;
    logic [LENGTH_BITS-1:0] capped_max_reg;
    logic [SUM_W-1:0]       total_sum_reg;
    logic [LENGTH_BITS-1:0] total_min_reg;
    logic [LENGTH_BITS-1:0] total_max_reg;
    logic                   overflow_seen_reg;

    // Judging datapath.
    logic [CNT_W-1:0]       n_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [MUL_P_W-1:0]     rhs_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [LENGTH_BITS-1:0] rd_data_reg;
    logic                   out_keep_reg;
    logic                   out_last_reg;

    // Length memory.
    logic [LENGTH_BITS-1:0] length_mem [MAX_RECTS];

    // Control decode.
    logic                   in_accept;
    logic                   out_accept;
    logic                   room;
    logic                   is_last_entry;
    logic [IDX_W-1:0]       rd_addr;
    mul_sel_t               mul_sel;
    logic [MUL_A_W-1:0]     mul_a;
    logic [MUL_B_W-1:0]     mul_b;
    logic [MUL_P_W-1:0]     mul_p;
    logic [LENGTH_BITS-1:0] rect_w;
    logic [LENGTH_BITS-1:0] rect_h;
    logic [LENGTH_BITS-1:0] len;
    logic                   len_capped;
    logic [CNT_W-1:0]       sel_count;
    logic [SUM_W-1:0]       sel_sum;
    logic [LENGTH_BITS-1:0] sel_min;
    logic [LENGTH_BITS-1:0] sel_max;
    logic [31:0]            idx_ext;

    assign cfg_ready  = 1'b1;
    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign out_accept = m_axis_tvalid && m_axis_tready;

    // Length of the incoming rectangle and its classification.
    assign rect_w     = s_axis_tdata[11:0];
    assign rect_h     = s_axis_tdata[23:12];
    assign len        = (rect_w > rect_h) ? rect_w : rect_h;
    assign len_capped = (len <= length_cap_reg);
    assign room       = (entry_count_reg < CNT_W'(MAX_RECTS));

    assign is_last_entry = (CNT_W'(idx_reg) + CNT_W'(1) == entry_count_reg);

    // Reference set: capped lengths if any qualify, otherwise all lengths.
    always_comb
    begin
        if (capped_count_reg != '0)
        begin
            sel_count = capped_count_reg;
            sel_sum   = capped_sum_reg;
            sel_min   = capped_min_reg;
            sel_max   = capped_max_reg;
        end
        else
        begin
            sel_count = entry_count_reg;
            sel_sum   = total_sum_reg;
            sel_min   = total_min_reg;
            sel_max   = total_max_reg;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && s_axis_tlast)
                begin
                    state_next = S_TRIM;
                end
            end
            S_TRIM:  state_next = S_RHS;
            S_RHS:   state_next = S_SCALE;
            S_SCALE: state_next = S_LMUL;
            S_LMUL:  state_next = S_JUDGE;
            S_JUDGE: state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_accept)
                begin
                    state_next = is_last_entry ? S_IDLE : S_LMUL;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Output and datapath control decode.
    always_comb
    begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        mul_sel       = MUL_SEL_LEN;
        rd_addr       = idx_reg;
        case (state_reg)
            S_IDLE:  s_axis_tready = 1'b1;
            S_RHS:   mul_sel = MUL_SEL_RHS;
            S_EMIT:
            begin
                m_axis_tvalid = 1'b1;
                rd_addr       = idx_reg + IDX_W'(1);
            end
            default: ;
        endcase
    end

    // Shared multiplier operands: ratio times sum once, then length times 8n.
    always_comb
    begin
        case (mul_sel)
            MUL_SEL_RHS:
            begin
                mul_a = sum_reg;
                mul_b = MUL_B_W'(keep_ratio_reg);
            end
            default:
            begin
                mul_a = MUL_A_W'(rd_data_reg);
                mul_b = MUL_B_W'({n_reg, 3'b000});
            end
        endcase
    end

    tmsof_mul u_mul (
        .clk     (clk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_p)
    );

    // Length memory: written on load, read with registered data.
    always_ff @(posedge clk)
    begin
        if (in_accept && room)
        begin
            length_mem[entry_count_reg[IDX_W-1:0]] <= len;
        end
        rd_data_reg <= length_mem[rd_addr];
    end

    // Control state, configuration and set statistics.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            length_cap_reg    <= LENGTH_CAP_RST;
            keep_ratio_reg    <= KEEP_RATIO_RST;
            entry_count_reg   <= '0;
            capped_sum_reg    <= '0;
            capped_count_reg  <= '0;
            capped_min_reg    <= '1;
            capped_max_reg    <= '0;
            total_sum_reg     <= '0;
            total_min_reg     <= '1;
            total_max_reg     <= '0;
            overflow_seen_reg <= 1'b0;
            idx_reg           <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // Configuration transaction.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LENGTH_CAP: length_cap_reg <= cfg_data[LENGTH_BITS-1:0];
                    REG_KEEP_RATIO: keep_ratio_reg <= cfg_data[RATIO_W-1:0];
                    default: ;
                endcase
            end

            // Load one rectangle, or note that the set overflowed.
            if (in_accept)
            begin
                if (room)
                begin
                    entry_count_reg <= entry_count_reg + CNT_W'(1);
                    total_sum_reg   <= total_sum_reg + SUM_W'(len);
                    if (len < total_min_reg)
                    begin
                        total_min_reg <= len;
                    end
                    if (len > total_max_reg)
                    begin
                        total_max_reg <= len;
                    end
                    if (len_capped)
                    begin
                        capped_sum_reg   <= capped_sum_reg + SUM_W'(len);
                        capped_count_reg <= capped_count_reg + CNT_W'(1);
                        if (len < capped_min_reg)
                        begin
                            capped_min_reg <= len;
                        end
                        if (len > capped_max_reg)
                        begin
                            capped_max_reg <= len;
                        end
                    end
                end
                else
                begin
                    overflow_seen_reg <= 1'b1;
                end
            end

            // Step through the stored entries; clear the set after the last.
            if (out_accept)
            begin
                if (is_last_entry)
                begin
                    idx_reg           <= '0;
                    entry_count_reg   <= '0;
                    capped_sum_reg    <= '0;
                    capped_count_reg  <= '0;
                    capped_min_reg    <= '1;
                    capped_max_reg    <= '0;
                    total_sum_reg     <= '0;
                    total_min_reg     <= '1;
                    total_max_reg     <= '0;
                    overflow_seen_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
            end
        end
    end

    // Trimmed reference, scale and judgement registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_TRIM)
        begin
            if (sel_count > CNT_W'(2))
            begin
                n_reg   <= sel_count - CNT_W'(2);
                sum_reg <= sel_sum - (SUM_W'(sel_min) + SUM_W'(sel_max));
            end
            else
            begin
                n_reg   <= sel_count;
                sum_reg <= sel_sum;
            end
        end
        if (state_reg == S_SCALE)
        begin
            rhs_reg <= mul_p;
        end
        if (state_reg == S_JUDGE)
        begin
            out_keep_reg <= (mul_p <= rhs_reg);
            out_last_reg <= is_last_entry;
        end
    end

    // Result payload.
    assign idx_ext      = 32'(idx_reg);
    assign m_axis_tdata = {overflow_seen_reg, out_keep_reg, idx_ext[RECT_IDX_W-1:0]};
    assign m_axis_tlast = out_last_reg;

    // The block never loads while a result is on offer.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    // The fill count never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CNT_W'(MAX_RECTS))
        else $error("entry count beyond capacity");

    // Capped entries are a subset of the stored ones.
    assert property (@(posedge clk) disable iff (!rst_n)
        capped_count_reg <= entry_count_reg)
        else $error("capped count exceeds entry count");

    // Every judged index refers to an entry of the current set.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (CNT_W'(idx_reg) < entry_count_reg))
        else $error("result index outside the stored set");

    // The end of a set closes the input on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input still open after the last rectangle");

endmodule

// ===== tb/sv/trimmed_mean_size_outlier_filter_test.sv =====
// Self-checking testbench for the trimmed-mean size outlier filter.
`timescale 1ns / 1ps

module trimmed_mean_size_outlier_filter_test
    import tmsof_pkg::*;
();

    localparam int      SETTLE_CYCLES = 12;
    localparam int      LONG_HOLD     = 300;
    localparam int      TOTAL_ITEMS   = 430;
    localparam realtime RUN_LIMIT     = 2ms;

    // One expected verdict on a stored rectangle.
    typedef struct {
        bit [RECT_IDX_W-1:0] index;
        bit                  keep;
        bit                  overflowed;
        bit                  last;
    } rect_verdict_t;

    // Tracks the set being loaded, predicts the verdicts and checks results.
    class rect_scoreboard;
        bit [LENGTH_BITS-1:0] length_cap = LENGTH_CAP_RST;
        bit [RATIO_W-1:0]     keep_ratio = KEEP_RATIO_RST;
        bit [LENGTH_BITS-1:0] lengths [MAX_RECTS];
        int unsigned          stored;
        int unsigned          capped_count;
        longint unsigned      capped_sum;
        longint unsigned      total_sum;
        bit [LENGTH_BITS-1:0] capped_min = '1;
        bit [LENGTH_BITS-1:0] capped_max;
        bit [LENGTH_BITS-1:0] total_min = '1;
        bit [LENGTH_BITS-1:0] total_max;
        bit                   dropped;
        rect_verdict_t        verdicts [$];
        int unsigned          errors;
        int unsigned          rects_seen;
        int unsigned          sets_closed;
        int unsigned          overflow_sets;
        int unsigned          results_checked;

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function int unsigned pending();
            return verdicts.size();
        endfunction

        function void set_config(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
            if (idx == REG_LENGTH_CAP)
                length_cap = data[LENGTH_BITS-1:0];
            else if (idx == REG_KEEP_RATIO)
                keep_ratio = data[RATIO_W-1:0];
        endfunction

        // Called for every accepted input transaction.
        function void note_rect(bit [11:0] w, bit [11:0] h, bit last);
            bit [LENGTH_BITS-1:0] len;
            longint unsigned      n;
            longint unsigned      sum;
            longint unsigned      scale;
            longint unsigned      rhs;
            int unsigned          i;
            len = (w > h) ? w : h;
            rects_seen++;
            // A full store drops the rectangle but remembers that it happened.
            if (stored >= MAX_RECTS) begin
                dropped = 1'b1;
            end
            else begin
                lengths[stored] = len;
                stored++;
                total_sum += len;
                if (len < total_min) total_min = len;
                if (len > total_max) total_max = len;
                if (len <= length_cap) begin
                    capped_sum += len;
                    capped_count++;
                    if (len < capped_min) capped_min = len;
                    if (len > capped_max) capped_max = len;
                end
            end
            if (!last)
                return;

            // Reference set: capped lengths, or all of them when none qualify.
            if (capped_count > 0) begin
                n   = capped_count;
                sum = capped_sum;
                if (n > 2) begin
                    sum -= capped_min + capped_max;
                    n   -= 2;
                end
            end
            else begin
                n   = stored;
                sum = total_sum;
                if (n > 2) begin
                    sum -= total_min + total_max;
                    n   -= 2;
                end
            end
            scale = n * 8;
            rhs   = longint'(keep_ratio) * sum;
            for (i = 0; i < stored; i++)
                verdicts.insert(verdicts.size(),
                                '{RECT_IDX_W'(i), (lengths[i] * scale) <= rhs,
                                  dropped, (i + 1) == stored});

            // Every statistic of the set clears once it has been judged.
            sets_closed++;
            if (dropped) overflow_sets++;
            stored       = 0;
            capped_count = 0;
            capped_sum   = 0;
            total_sum    = 0;
            capped_min   = '1;
            capped_max   = '0;
            total_min    = '1;
            total_max    = '0;
            dropped      = 1'b0;
        endfunction

        // Called for every accepted output transaction.
        task check_result(logic [OUT_DATA_W-1:0] data, logic last);
            rect_verdict_t want;
            if (verdicts.size() == 0) begin
                report($sformatf("result with index %0d arrived with none expected",
                                 data[5:0]));
                return;
            end
            want = verdicts.pop_front();
            results_checked++;
            if (data[5:0] !== want.index)
                report($sformatf("rect_index %0d, expected %0d", data[5:0], want.index));
            if (data[6] !== want.keep)
                report($sformatf("keep %b on index %0d, expected %b",
                                 data[6], want.index, want.keep));
            if (data[7] !== want.overflowed)
                report($sformatf("overflowed %b on index %0d, expected %b",
                                 data[7], want.index, want.overflowed));
            if (last !== want.last)
                report($sformatf("last_result %b on index %0d, expected %b",
                                 last, want.index, want.last));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // [11:0] rect_width, [23:12] rect_height
    logic                  s_axis_tlast;   // last_rect
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [5:0] rect_index, [6] keep, [7] overflowed
    logic                  m_axis_tlast;   // last_result

    rect_scoreboard sb = new();
    bit             no_idle;
    int unsigned    hold_request;

    trimmed_mean_size_outlier_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // Offers one rectangle after a random gap and waits for its transaction.
    task automatic send_rect(bit [11:0] w, bit [11:0] h, bit last);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= {h, w};
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_rect(w, h, last);
    endtask

    // Stops offering input and waits until every predicted verdict has arrived.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One configuration transaction; only issued while the block is idle.
    task automatic write_register(bit [CFG_IDX_W-1:0] idx, int unsigned value);
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_config(idx, CFG_DATA_W'(value));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // One side of a rectangle: mostly near the set's typical size, sometimes wild.
    function automatic bit [11:0] pick_side(int unsigned base);
        int unsigned mode;
        int unsigned spread;
        mode   = $urandom_range(0, 9);
        spread = base / 4;
        if (mode == 0)
            return 12'($urandom);
        else if (mode == 1)
            return 12'($urandom_range(0, 15));
        else if (base + spread > 4095)
            return 12'($urandom_range(base - spread, 4095));
        else
            return 12'($urandom_range(base - spread, base + spread));
    endfunction

    // A set of rectangles sharing a typical size, with the larger side random.
    task automatic send_random_set(int unsigned set_size);
        int unsigned base;
        bit [11:0]   longer;
        bit [11:0]   shorter;
        int unsigned i;
        base = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                           : $urandom_range(20, 600);
        for (i = 0; i < set_size; i++) begin
            longer  = pick_side(base);
            shorter = 12'($urandom_range(0, longer));
            if ($urandom_range(0, 1))
                send_rect(longer, shorter, i + 1 == set_size);
            else
                send_rect(shorter, longer, i + 1 == set_size);
        end
    endtask

    // Result receiver: random stalls per transaction, plus a long hold on request.
    initial begin
        int unsigned stall;
        stall         = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata, m_axis_tlast);
                stall = no_idle ? 0 : $urandom_range(0, 4);
            end
            if (hold_request > 0) begin
                stall        = hold_request;
                hold_request = 0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #(RUN_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Main stimulus sequence.
    initial begin
        int unsigned sets_in_phase;
        int unsigned pick;
        int unsigned set_size;
        int unsigned j;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        no_idle       = 1'b0;
        hold_request  = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sets under the reset settings: single zero, single over cap,
        // two-entry set, trimmed set with an outlier, and a set entirely over cap.
        send_rect(12'd0, 12'd0, 1'b1);
        send_rect(12'd4095, 12'd0, 1'b1);
        send_rect(12'd300, 12'd100, 1'b0);
        send_rect(12'd50, 12'd400, 1'b1);
        send_rect(12'd100, 12'd100, 1'b0);
        send_rect(12'd110, 12'd90, 1'b0);
        send_rect(12'd4095, 12'd10, 1'b0);
        send_rect(12'd95, 12'd105, 1'b0);
        send_rect(12'd0, 12'd0, 1'b1);
        send_rect(12'd1000, 12'd2000, 1'b0);
        send_rect(12'd3000, 12'd500, 1'b0);
        send_rect(12'd4095, 12'd4095, 1'b1);
        wait_for_results();

        // Zero ratio: only zero lengths survive, and all survive on a zero sum.
        write_register(REG_KEEP_RATIO, 0);
        send_rect(12'd0, 12'd5, 1'b0);
        send_rect(12'd10, 12'd0, 1'b0);
        send_rect(12'd0, 12'd0, 1'b1);
        send_rect(12'd0, 12'd0, 1'b0);
        send_rect(12'd0, 12'd0, 1'b1);
        wait_for_results();

        // Zero cap with the widest ratio.
        write_register(REG_LENGTH_CAP, 0);
        write_register(REG_KEEP_RATIO, 255);
        send_rect(12'd0, 12'd0, 1'b0);
        send_rect(12'd1, 12'd0, 1'b0);
        send_rect(12'd3, 12'd2, 1'b1);
        wait_for_results();

        // Widest cap with the smallest nonzero ratio, alternating bit patterns.
        write_register(REG_LENGTH_CAP, 4095);
        write_register(REG_KEEP_RATIO, 1);
        send_rect(12'hAAA, 12'h555, 1'b0);
        send_rect(12'h555, 12'hAAA, 1'b0);
        send_rect(12'hFFF, 12'hFFF, 1'b1);
        wait_for_results();

        // Back-pressure: results held off while the next set keeps offering.
        write_register(REG_LENGTH_CAP, 450);
        write_register(REG_KEEP_RATIO, 12);
        hold_request = LONG_HOLD;
        no_idle      = 1'b1;
        send_random_set(12);
        send_random_set(12);
        no_idle      = 1'b0;
        wait_for_results();

        // Capacity boundary: a full store, then a set that overflows it.
        send_random_set(MAX_RECTS);
        wait_for_results();
        send_random_set(MAX_RECTS + 2);
        wait_for_results();

        // Random phases, each with fresh settings written while idle.
        while (sb.rects_seen < TOTAL_ITEMS) begin
            pick = $urandom_range(0, 5);
            write_register(REG_LENGTH_CAP, (pick == 0) ? 0 : (pick == 1) ? 4095 :
                                           (pick == 2) ? 450 : $urandom_range(0, 4095));
            pick = $urandom_range(0, 7);
            write_register(REG_KEEP_RATIO, (pick == 0) ? 1 : (pick == 1) ? 255 :
                                           (pick == 2) ? 12 : (pick == 3) ? 8 :
                                           (pick == 4) ? 0 : $urandom_range(1, 255));
            no_idle       = ($urandom_range(0, 4) == 0);
            sets_in_phase = $urandom_range(1, 4);
            for (j = 0; j < sets_in_phase; j++) begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    set_size = $urandom_range(MAX_RECTS - 4, MAX_RECTS + 8);
                else if (pick == 1)
                    set_size = $urandom_range(1, 2);
                else
                    set_size = $urandom_range(3, 12);
                send_random_set(set_size);
            end
            no_idle = 1'b0;
            wait_for_results();
        end

        $display("Ran %0d sets of %0d rectangles, %0d verdicts checked, %0d sets overflowed.",
                 sb.sets_closed, sb.rects_seen, sb.results_checked, sb.overflow_sets);
        $display("Settings swept cap and ratio extremes, zero ratio and a long output stall.");
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/tmsof_pkg.sv
rtl/core/tmsof_mul.sv
rtl/core/trimmed_mean_size_outlier_filter.sv
tb/sv/trimmed_mean_size_outlier_filter_test.sv
